// ----- src/fcbf_pkg.sv -----
// Shared types and constants for the flow-controlled byte FIFO.
`timescale 1ns / 1ps

package fcbf_pkg;

  // Default capacity of the byte store, in bytes.
  localparam int DEPTH_DEFAULT = 64;

  // Fixed field widths of the item interface.
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int TOTAL_W = 32;

  // Most bytes that one read or peek may return.
  localparam logic [LEN_W-1:0] RESULT_LIMIT = 7'd64;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_END   = 2'd3
  } command_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_STREAM = 1'b1
  } state_t;

  typedef struct packed {
    command_t                command;
    logic [BYTE_W-1:0]       data_byte;
    logic [LEN_W-1:0]        length;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0]       out_byte;
    logic                    byte_valid;
    logic                    last;
    logic                    accepted;
    logic [LEN_W-1:0]        fill_level;
    logic [LEN_W-1:0]        free_space;
    logic [TOTAL_W-1:0]      total_written;
    logic [TOTAL_W-1:0]      total_read;
    logic                    input_closed;
    logic                    at_eof;
  } result_t;

endpackage

// ----- src/fcbf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fcbf_ram #(
  parameter int WIDTH = fcbf_pkg::BYTE_W,
  parameter int DEPTH = fcbf_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/flow_controlled_byte_fifo_core.sv -----
// Top level of the flow-controlled byte FIFO: command sequencer and status.
`timescale 1ns / 1ps

// This block keeps a circular byte FIFO of DEPTH bytes and takes one command
// item at a time: an item is accepted at a rising edge where start is high and
// busy is low. Every item answers with one or more results, each shown for
// exactly one cycle while strobe is high; the receiver cannot stall, so it must
// take every result in the cycle it appears. The first result of an item always
// appears in the cycle right after the item was accepted. A write, an end
// command, or a read or peek that returns at most one byte, finishes in that
// single cycle and the block is ready again at once. A read or peek that returns
// n > 1 bytes (n is the requested length, capped at what is held and at 64)
// streams one byte per cycle, and busy stays high until the last address has
// gone to the byte store; the single read port of that store sets this pace.
// All status fields (fill level, free space, totals, input ended, end of
// stream) describe the FIFO after the whole item, so they stay the same on
// every result of a read. The totals saturate at all ones. The byte store is
// not cleared after reset; bytes are only read after they have been written,
// so no clearing pass is needed and the block is ready right after reset.

module flow_controlled_byte_fifo_core #(
  parameter int DEPTH = fcbf_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fcbf_pkg::request_t request,
  output logic               strobe,
  output fcbf_pkg::result_t  result
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > fcbf_pkg::LEN_W) ? CNT_W : fcbf_pkg::LEN_W;
  localparam int ADV_W = ((PTR_W > fcbf_pkg::LEN_W) ? PTR_W : fcbf_pkg::LEN_W) + 1;
  localparam int SUM_W = fcbf_pkg::TOTAL_W + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [fcbf_pkg::LEN_W-1:0] ONE_BYTE = fcbf_pkg::LEN_W'(1);

  // Step a ring pointer by one slot, wrapping at the end of the store.
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  // Sequencer state.
  fcbf_pkg::state_t state, state_next;

  // FIFO state.
  logic [PTR_W-1:0]             write_pointer, write_pointer_next;
  logic [PTR_W-1:0]             read_pointer, read_pointer_next;
  logic [CNT_W-1:0]             held_count, held_count_next;
  logic [fcbf_pkg::TOTAL_W-1:0] written_total, written_total_next;
  logic [fcbf_pkg::TOTAL_W-1:0] read_total, read_total_next;
  logic                         ended_flag, ended_flag_next;

  // Streaming walk through the store for a read or a peek.
  logic [PTR_W-1:0]             cur_ptr, cur_ptr_next;
  logic [fcbf_pkg::LEN_W-1:0]   remain, remain_next;

  // Per-result flags that go out with the strobe.
  logic strobe_next;
  logic res_valid, res_valid_next;
  logic res_last, res_last_next;
  logic res_accepted, res_accepted_next;

  // Byte store ports.
  logic                        ram_we;
  logic [PTR_W-1:0]            ram_raddr;
  logic [fcbf_pkg::BYTE_W-1:0] ram_rdata;

  // Values derived from the incoming item.
  logic                        accept;
  logic                        has_space;
  logic [fcbf_pkg::LEN_W-1:0]  len_clip;
  logic [CMP_W-1:0]            held_cmp;
  logic [CMP_W-1:0]            len_cmp;
  logic [fcbf_pkg::LEN_W-1:0]  take;
  logic [ADV_W-1:0]            adv;
  logic [SUM_W-1:0]            rd_sum;
  logic [CMP_W-1:0]            free_w;

  fcbf_ram #(
    .WIDTH (fcbf_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata (request.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept = start && !busy;

  // The number of bytes a read or peek returns: the request, capped at the
  // result limit and at what is held.
  always_comb begin
    len_clip = (request.length > fcbf_pkg::RESULT_LIMIT) ?
               fcbf_pkg::RESULT_LIMIT : request.length;
    held_cmp = CMP_W'(held_count);
    len_cmp  = CMP_W'(len_clip);
    take     = (held_cmp < len_cmp) ? fcbf_pkg::LEN_W'(held_count) : len_clip;
    has_space = held_count < CNT_W'(DEPTH);
    // The pop never passes the write pointer, so one conditional subtract wraps it.
    adv = ADV_W'(read_pointer) + ADV_W'(take);
    if (adv >= ADV_W'(DEPTH)) begin
      adv = adv - ADV_W'(DEPTH);
    end
    rd_sum = {1'b0, read_total} + SUM_W'(take);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      fcbf_pkg::ST_IDLE: begin
        if (accept && (request.command == fcbf_pkg::CMD_READ ||
                       request.command == fcbf_pkg::CMD_PEEK) && take > ONE_BYTE) begin
          state_next = fcbf_pkg::ST_STREAM;
        end
      end
      fcbf_pkg::ST_STREAM: begin
        if (remain == ONE_BYTE) begin
          state_next = fcbf_pkg::ST_IDLE;
        end
      end
      default: state_next = fcbf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and the read address of the store.
  always_comb begin
    case (state)
      fcbf_pkg::ST_STREAM: begin
        busy      = 1'b1;
        ram_raddr = cur_ptr;
      end
      default: begin
        busy      = 1'b0;
        ram_raddr = read_pointer;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    held_count_next    = held_count;
    written_total_next = written_total;
    read_total_next    = read_total;
    ended_flag_next    = ended_flag;
    cur_ptr_next       = cur_ptr;
    remain_next        = remain;
    strobe_next        = 1'b0;
    res_valid_next     = res_valid;
    res_last_next      = res_last;
    res_accepted_next  = res_accepted;
    ram_we             = 1'b0;

    if (state == fcbf_pkg::ST_STREAM) begin
      // One more byte of a multi-byte answer each cycle.
      strobe_next       = 1'b1;
      res_valid_next    = 1'b1;
      res_last_next     = (remain == ONE_BYTE);
      res_accepted_next = 1'b0;
      remain_next       = remain - ONE_BYTE;
      cur_ptr_next      = next_slot(cur_ptr);
    end else if (accept) begin
      strobe_next       = 1'b1;
      res_valid_next    = 1'b0;
      res_last_next     = 1'b1;
      res_accepted_next = 1'b0;
      case (request.command)
        fcbf_pkg::CMD_WRITE: begin
          if (has_space) begin
            ram_we             = 1'b1;
            res_accepted_next  = 1'b1;
            write_pointer_next = next_slot(write_pointer);
            held_count_next    = held_count + CNT_W'(1);
            if (written_total != '1) begin
              written_total_next = written_total + fcbf_pkg::TOTAL_W'(1);
            end
          end
        end
        fcbf_pkg::CMD_END: begin
          ended_flag_next = 1'b1;
        end
        fcbf_pkg::CMD_READ, fcbf_pkg::CMD_PEEK: begin
          if (take != '0) begin
            // The first byte is read now; the rest follow in the stream state.
            res_valid_next = 1'b1;
            res_last_next  = (take == ONE_BYTE);
            remain_next    = take - ONE_BYTE;
            cur_ptr_next   = next_slot(read_pointer);
            if (request.command == fcbf_pkg::CMD_READ) begin
              read_pointer_next = PTR_W'(adv);
              held_count_next   = held_count - CNT_W'(take);
              read_total_next   = rd_sum[SUM_W-1] ? '1 : rd_sum[fcbf_pkg::TOTAL_W-1:0];
            end
          end
        end
        default: begin
          res_last_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fcbf_pkg::ST_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      held_count    <= '0;
      written_total <= '0;
      read_total    <= '0;
      ended_flag    <= 1'b0;
      cur_ptr       <= '0;
      remain        <= '0;
      strobe        <= 1'b0;
    end else begin
      state         <= state_next;
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      held_count    <= held_count_next;
      written_total <= written_total_next;
      read_total    <= read_total_next;
      ended_flag    <= ended_flag_next;
      cur_ptr       <= cur_ptr_next;
      remain        <= remain_next;
      strobe        <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    res_valid    <= res_valid_next;
    res_last     <= res_last_next;
    res_accepted <= res_accepted_next;
  end

  // Status never changes while a result is shown, so it is read straight from
  // the FIFO state, which already holds the values after the whole item.
  always_comb begin
    free_w                = CMP_W'(DEPTH) - CMP_W'(held_count);
    result.out_byte       = res_valid ? ram_rdata : '0;
    result.byte_valid     = res_valid;
    result.last           = res_last;
    result.accepted       = res_accepted;
    result.fill_level     = fcbf_pkg::LEN_W'(held_cmp);
    result.free_space     = fcbf_pkg::LEN_W'(free_w);
    result.total_written  = written_total;
    result.total_read     = read_total;
    result.input_closed   = ended_flag;
    result.at_eof         = ended_flag && (held_count == '0);
  end

endmodule

// ----- src/fcbf_checker.sv -----
// Port-level checks for the byte FIFO core and the bind that attaches them.
`timescale 1ns / 1ps

module fcbf_checker #(
  parameter int DEPTH = fcbf_pkg::DEPTH_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input fcbf_pkg::request_t request,
  input logic               strobe,
  input fcbf_pkg::result_t  result
);

  // Every accepted item shows its first result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> strobe)
    else $error("accepted item produced no result in the next cycle");

  // A write answers with exactly one result that carries no byte.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == fcbf_pkg::CMD_WRITE |=>
      result.last && !result.byte_valid)
    else $error("write result is not a single empty result");

  // The block stays busy while more results of the same item are due.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("ready while an answer is still streaming");

  // Once the final result is out, the block is ready for the next item.
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("still busy on the final result");

  // On every result, fill level and free space add up to the capacity.
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> fcbf_pkg::LEN_W'(result.fill_level + result.free_space) ==
               fcbf_pkg::LEN_W'(DEPTH))
    else $error("fill level and free space disagree");

endmodule

bind flow_controlled_byte_fifo_core fcbf_checker #(.DEPTH(DEPTH)) u_fcbf_checker (.*);

// ----- tb/flow_controlled_byte_fifo_core_tb.sv -----
// Self-checking testbench for the flow-controlled byte FIFO core.
`timescale 1ns / 1ps

module flow_controlled_byte_fifo_core_tb;
  import fcbf_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int MAX_PRINTED = 50;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     strobe;
  result_t  result;

  flow_controlled_byte_fifo_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
  );

  // Software image of the FIFO. It is advanced once per accepted item, and
  // every result that item must produce goes into awaited_results in order.
  logic [BYTE_W-1:0]  fifo_image [DEPTH];
  int                 image_wr_ptr;
  int                 image_rd_ptr;
  int                 image_held;
  logic [TOTAL_W-1:0] image_written;
  logic [TOTAL_W-1:0] image_read;
  logic               image_ended;

  result_t awaited_results[$];
  int      error_count;
  int      items_sent;
  bit      quiet_sender;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs on busy or never delivers results.
  initial begin
    #(3_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(name, got, want);
    end
  endtask

  function automatic int next_slot(input int p);
    return (p + 1 == DEPTH) ? 0 : p + 1;
  endfunction

  // Builds one result from the image as it stands after the whole item.
  function automatic result_t status_result(input logic [BYTE_W-1:0] data,
                                            input logic valid, input logic is_last,
                                            input logic stored);
    result_t r;
    r.out_byte      = data;
    r.byte_valid    = valid;
    r.last          = is_last;
    r.accepted      = stored;
    r.fill_level    = LEN_W'(image_held);
    r.free_space    = LEN_W'(DEPTH - image_held);
    r.total_written = image_written;
    r.total_read    = image_read;
    r.input_closed  = image_ended;
    r.at_eof        = image_ended && (image_held == 0);
    return r;
  endfunction

  task automatic predict_fifo_response(input request_t item);
    logic [BYTE_W-1:0] returned[$];
    logic [TOTAL_W:0]  read_sum;
    logic              stored;
    int                take;
    int                p;
    case (item.command)
      CMD_WRITE: begin
        stored = 1'b0;
        if (image_held < DEPTH) begin
          fifo_image[image_wr_ptr] = item.data_byte;
          image_wr_ptr = next_slot(image_wr_ptr);
          image_held++;
          if (image_written != '1) image_written++;
          stored = 1'b1;
        end
        awaited_results.push_back(status_result('0, 1'b0, 1'b1, stored));
      end
      CMD_END: begin
        image_ended = 1'b1;
        awaited_results.push_back(status_result('0, 1'b0, 1'b1, 1'b0));
      end
      default: begin
        // Read and peek: at most what is held, and never beyond the result limit.
        take = item.length;
        if (take > image_held) take = image_held;
        if (take > int'(RESULT_LIMIT)) take = RESULT_LIMIT;
        p = image_rd_ptr;
        for (int i = 0; i < take; i++) begin
          returned.push_back(fifo_image[p]);
          p = next_slot(p);
        end
        if (item.command == CMD_READ) begin
          image_rd_ptr = p;
          image_held -= take;
          read_sum = {1'b0, image_read} + take;
          image_read = read_sum[TOTAL_W] ? '1 : read_sum[TOTAL_W-1:0];
        end
        if (take == 0) begin
          awaited_results.push_back(status_result('0, 1'b0, 1'b1, 1'b0));
        end else begin
          for (int i = 0; i < take; i++) begin
            awaited_results.push_back(status_result(returned[i], 1'b1, i == take - 1, 1'b0));
          end
        end
      end
    endcase
  endtask

  // Mostly back-to-back or short gaps, with an occasional long pause.
  function automatic int pick_gap();
    int r;
    if (quiet_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drives one item at the falling edge and holds it until the block takes it.
  // Start is only lowered when a gap follows, so it is never dropped and raised
  // again in the same time step.
  task automatic send_item(input request_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predict_fifo_response(item);
    items_sent++;
  endtask

  // Fields that the command ignores are filled with random values.
  function automatic request_t make_request(input command_t cmd,
                                            input logic [BYTE_W-1:0] data,
                                            input logic [LEN_W-1:0] len);
    request_t r;
    r.command   = cmd;
    r.data_byte = (cmd == CMD_WRITE) ? data : BYTE_W'($urandom);
    r.length    = (cmd == CMD_READ || cmd == CMD_PEEK) ? len : LEN_W'($urandom_range(0, 64));
    return r;
  endfunction

  // Lengths mostly fall between one and the current fill level, with zero, the
  // full result limit and random lengths up to it mixed in.
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'(64);
    if (r == 2) return LEN_W'($urandom_range(0, 64));
    return LEN_W'($urandom_range(1, (image_held > 0) ? image_held : 1));
  endfunction

  function automatic request_t random_request(input int write_pct, input bit allow_end);
    int r;
    r = $urandom_range(0, 99);
    if (allow_end && r < 3) return make_request(CMD_END, '0, '0);
    if (r < write_pct) return make_request(CMD_WRITE, BYTE_W'($urandom), '0);
    if ($urandom_range(0, 99) < 65) return make_request(CMD_READ, '0, pick_length());
    return make_request(CMD_PEEK, '0, pick_length());
  endfunction

  // Empty answers, byte extremes, zero length, lengths beyond the holdings.
  task automatic test_directed();
    send_item(make_request(CMD_READ, '0, 7'd5));
    send_item(make_request(CMD_PEEK, '0, 7'd0));
    send_item(make_request(CMD_READ, '0, 7'd0));
    send_item(make_request(CMD_WRITE, 8'h00, '0));
    send_item(make_request(CMD_WRITE, 8'hFF, '0));
    send_item(make_request(CMD_WRITE, 8'hA5, '0));
    send_item(make_request(CMD_WRITE, 8'h5A, '0));
    send_item(make_request(CMD_PEEK, '0, 7'd0));
    send_item(make_request(CMD_PEEK, '0, 7'd2));
    send_item(make_request(CMD_PEEK, '0, 7'd64));
    send_item(make_request(CMD_READ, '0, 7'd1));
    send_item(make_request(CMD_READ, '0, 7'd64));
    send_item(make_request(CMD_READ, '0, 7'd1));
    send_item(make_request(CMD_WRITE, 8'h80, '0));
    send_item(make_request(CMD_WRITE, 8'h01, '0));
    send_item(make_request(CMD_READ, '0, 7'd2));
  endtask

  // Fills the store past the wrap point, drops writes when full, then takes
  // the whole content with one peek and one read of the result limit.
  task automatic test_fill_to_full();
    while (image_held < DEPTH) begin
      send_item(make_request(CMD_WRITE, BYTE_W'($urandom), '0));
    end
    repeat (3) send_item(make_request(CMD_WRITE, BYTE_W'($urandom), '0));
    send_item(make_request(CMD_PEEK, '0, 7'd64));
    send_item(make_request(CMD_READ, '0, 7'd64));
    send_item(make_request(CMD_READ, '0, 7'd64));
  endtask

  // Phases that lean toward filling or draining, so the fill level keeps
  // crossing both the empty and the full boundary.
  task automatic test_random_traffic(input int item_budget);
    int stop_at;
    int phase_len;
    int write_pct;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      phase_len = $urandom_range(10, 50);
      case ($urandom_range(0, 2))
        0:       write_pct = 80;
        1:       write_pct = 25;
        default: write_pct = 50;
      endcase
      quiet_sender = ($urandom_range(0, 4) == 0);
      repeat (phase_len) send_item(random_request(write_pct, 1'b0));
    end
    quiet_sender = 1'b0;
  endtask

  // End of input: writes are still taken afterward, and end of stream shows
  // once the store has drained.
  task automatic test_end_of_input();
    repeat (3) send_item(make_request(CMD_WRITE, BYTE_W'($urandom), '0));
    send_item(make_request(CMD_END, '0, '0));
    repeat (2) send_item(make_request(CMD_WRITE, BYTE_W'($urandom), '0));
    send_item(make_request(CMD_PEEK, '0, 7'd64));
    while (image_held > 0) begin
      send_item(make_request(CMD_READ, '0, LEN_W'($urandom_range(1, 8))));
    end
    send_item(make_request(CMD_READ, '0, 7'd3));
    send_item(make_request(CMD_END, '0, '0));
    repeat (40) send_item(random_request(50, 1'b1));
  endtask

  // Every strobed result is matched against the oldest pending expectation.
  initial begin : result_checker
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && strobe === 1'b1) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing pending", result[31:0], '0);
        end else begin
          want = awaited_results.pop_front();
          compare_field("out_byte", result.out_byte, want.out_byte);
          compare_field("byte_valid", result.byte_valid, want.byte_valid);
          compare_field("last", result.last, want.last);
          compare_field("accepted", result.accepted, want.accepted);
          compare_field("fill_level", result.fill_level, want.fill_level);
          compare_field("free_space", result.free_space, want.free_space);
          compare_field("total_written", result.total_written, want.total_written);
          compare_field("total_read", result.total_read, want.total_read);
          compare_field("input_closed", result.input_closed, want.input_closed);
          compare_field("at_eof", result.at_eof, want.at_eof);
        end
      end else if (!rst && strobe !== 1'b0) begin
        report_mismatch("strobe unknown", 32'(strobe), '0);
      end
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;
    error_count   = 0;
    items_sent    = 0;
    quiet_sender  = 1'b0;
    image_wr_ptr  = 0;
    image_rd_ptr  = 0;
    image_held    = 0;
    image_written = '0;
    image_read    = '0;
    image_ended   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_to_full();
    test_random_traffic(310);
    test_end_of_input();

    @(negedge clk);
    start <= 1'b0;
    // The longest answer still in flight is one full read of the result limit.
    repeat (200) begin
      if (awaited_results.size() == 0) break;
      @(posedge clk);
    end
    if (awaited_results.size() != 0) begin
      report_mismatch("results never delivered", awaited_results.size(), '0);
    end
    repeat (80) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
